FILE: src/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg
// Shared types and constants of the column predicate scan filter.
// ----------------------------------------------------------------------------
package pcsf_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned CMP_W    = 3;
  localparam int unsigned ACTIVE_W = 4;
  localparam int unsigned IDX_W    = 32;
  localparam int unsigned IN_DATA_W  = 264;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  localparam logic KIND_INDEX = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam logic [CMP_W-1:0] CMP_GT = 3'd0;
  localparam logic [CMP_W-1:0] CMP_GE = 3'd1;
  localparam logic [CMP_W-1:0] CMP_LT = 3'd2;
  localparam logic [CMP_W-1:0] CMP_LE = 3'd3;
  localparam logic [CMP_W-1:0] CMP_EQ = 3'd4;
  localparam logic [CMP_W-1:0] CMP_NE = 3'd5;

  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic              last_row;
    logic [SLOT_W-1:0] slot;
    logic              column;
    logic [CMP_W-1:0]  cmp;
    logic              ends;
    logic [DATA_W-1:0] mult;
    logic [DATA_W-1:0] thr;
    logic [DATA_W-1:0] price;
    logic [DATA_W-1:0] volume;
    logic              any;
    logic              group;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] cnt;
    logic             last;
  } res_t;

endpackage

FILE: src/pcsf_cell.sv
// ----------------------------------------------------------------------------
// pcsf_cell
// One predicate term: holds its table entry, scales the chosen column in two
// stages and folds the comparison into the running AND/OR result.
// ----------------------------------------------------------------------------
module pcsf_cell
  import pcsf_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned NW  = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [NW-1:0] active_n_i,
  input  item_t         item_i,
  output item_t         item_o
);

  localparam bit HAS_SLOT = (IDX < (1 << SLOT_W));

  typedef struct packed {
    item_t             item;
    logic [DATA_W-1:0] pp0;
    logic [HALF_W-1:0] pp1;
    logic [HALF_W-1:0] pp2;
    logic [DATA_W-1:0] thr;
    logic [CMP_W-1:0]  cmp;
    logic              ends;
  } stage_t;

  logic [DATA_W-1:0] tm_mult_q;
  logic [DATA_W-1:0] tm_thr_q;
  logic              tm_column_q;
  logic [CMP_W-1:0]  tm_cmp_q;
  logic              tm_ends_q;

  stage_t a_d, a_q;
  item_t  b_d, b_q;

  logic              load_hit;
  logic [DATA_W-1:0] col;
  logic [DATA_W-1:0] lhs;
  logic              holds;
  logic              term_en;
  logic              term_close;
  logic              grp;

  assign load_hit = item_i.valid && (item_i.cmd == CMD_LOAD) && HAS_SLOT &&
                    (item_i.slot == SLOT_W'(IDX));

  always_ff @(posedge clk_i) begin
    if (en_i && load_hit) begin
      tm_mult_q   <= item_i.mult;
      tm_thr_q    <= item_i.thr;
      tm_column_q <= item_i.column;
      tm_cmp_q    <= item_i.cmp;
      tm_ends_q   <= item_i.ends;
    end
  end

  always_comb begin
    col       = tm_column_q ? item_i.volume : item_i.price;
    a_d.item  = item_i;
    a_d.pp0   = col[HALF_W-1:0] * tm_mult_q[HALF_W-1:0];
    a_d.pp1   = HALF_W'(col[DATA_W-1:HALF_W] * tm_mult_q[HALF_W-1:0]);
    a_d.pp2   = HALF_W'(col[HALF_W-1:0] * tm_mult_q[DATA_W-1:HALF_W]);
    a_d.thr   = tm_thr_q;
    a_d.cmp   = tm_cmp_q;
    a_d.ends  = tm_ends_q;
  end

  always_comb begin
    lhs = a_q.pp0 + {a_q.pp1 + a_q.pp2, {HALF_W{1'b0}}};
    case (a_q.cmp)
      CMP_GT:  holds = $signed(lhs) >  $signed(a_q.thr);
      CMP_GE:  holds = $signed(lhs) >= $signed(a_q.thr);
      CMP_LT:  holds = $signed(lhs) <  $signed(a_q.thr);
      CMP_LE:  holds = $signed(lhs) <= $signed(a_q.thr);
      CMP_EQ:  holds = lhs == a_q.thr;
      CMP_NE:  holds = lhs != a_q.thr;
      default: holds = 1'b0;
    endcase
    term_en    = NW'(IDX) < active_n_i;
    term_close = a_q.ends || (NW'(IDX) == (active_n_i - NW'(1)));
    grp        = a_q.item.group && holds;
    b_d        = a_q.item;
    if (a_q.item.valid && (a_q.item.cmd == CMD_ROW) && term_en) begin
      if (term_close) begin
        b_d.any   = a_q.item.any || grp;
        b_d.group = 1'b1;
      end else begin
        b_d.group = grp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign item_o = b_q;

endmodule

FILE: src/pcsf_result_unit.sv
// ----------------------------------------------------------------------------
// pcsf_result_unit
// Row and match counters at the end of the chain and a small result queue
// that takes up to two results per row and releases one per transfer.
// ----------------------------------------------------------------------------
module pcsf_result_unit
  import pcsf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  output logic  en_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  res_t             mem_q [Q_DEPTH];
  logic [Q_AW-1:0]  wp_q, rp_q, wp_d, rp_d;
  logic [Q_CW-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0] row_q, row_d, pass_q, pass_d;

  logic             tail;
  logic [IDX_W-1:0] pass_new;
  res_t             idx_e, cnt_e, first_e;
  logic [1:0]       wr_n;
  logic             pop;

  assign en_o        = (cnt_q <= Q_CW'(Q_DEPTH - 2));
  assign res_valid_o = (cnt_q != '0);
  assign res_o       = mem_q[rp_q];
  assign pop         = res_valid_o && res_ready_i;
  assign tail        = en_o && item_i.valid && (item_i.cmd == CMD_ROW);

  always_comb begin
    pass_new   = (item_i.any && (pass_q != '1)) ? pass_q + IDX_W'(1) : pass_q;
    idx_e.kind = KIND_INDEX;
    idx_e.idx  = row_q;
    idx_e.cnt  = '0;
    idx_e.last = !item_i.last_row;
    cnt_e.kind = KIND_COUNT;
    cnt_e.idx  = '0;
    cnt_e.cnt  = pass_new;
    cnt_e.last = 1'b1;
    first_e    = item_i.any ? idx_e : cnt_e;
    wr_n       = tail ? (2'(item_i.any) + 2'(item_i.last_row)) : 2'd0;
    row_d      = row_q;
    pass_d     = pass_q;
    if (tail) begin
      row_d  = item_i.last_row ? '0 : row_q + IDX_W'(1);
      pass_d = item_i.last_row ? '0 : pass_new;
    end
    wp_d  = wp_q + Q_AW'(wr_n);
    rp_d  = rp_q + Q_AW'(pop);
    cnt_d = cnt_q + Q_CW'(wr_n) - Q_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) begin
      mem_q[wp_q] <= first_e;
    end
    if (wr_n == 2'd2) begin
      mem_q[wp_q + Q_AW'(1)] <= cnt_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      cnt_q  <= cnt_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

endmodule

FILE: src/column_predicate_scan_filter_unit.sv
// ----------------------------------------------------------------------------
// column_predicate_scan_filter_unit
// Throughput: one item per cycle while the result queue has room for two
// results; each term cell has a multiply stage and a compare stage, and a
// row giving two results needs two output transfers.
// Reset clears the chain, counters and result queue; active_terms resets to 1.
// Term table entries are not reset and must be loaded before use.
// ----------------------------------------------------------------------------
module column_predicate_scan_filter_unit
  import pcsf_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ACTIVE_W-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // term_slot, term_column, term_compare, term_multiplier, term_threshold,
  // term_ends_group, price, volume
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // row_index, match_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int unsigned NW = $clog2(MAX_TERMS + 1);

  logic [ACTIVE_W-1:0] active_q;
  logic [NW-1:0]       active_n;
  logic                en;
  item_t               chain [MAX_TERMS+1];
  res_t                res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_W'(1);
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (active_q == '0) begin
      active_n = NW'(1);
    end else if (32'(active_q) > MAX_TERMS) begin
      active_n = NW'(MAX_TERMS);
    end else begin
      active_n = NW'(active_q);
    end
  end

  always_comb begin
    chain[0].valid    = s_axis_tvalid;
    chain[0].cmd      = s_axis_tuser;
    chain[0].last_row = s_axis_tlast;
    chain[0].slot     = s_axis_tdata[2:0];
    chain[0].column   = s_axis_tdata[3];
    chain[0].cmp      = s_axis_tdata[6:4];
    chain[0].mult     = s_axis_tdata[70:7];
    chain[0].thr      = s_axis_tdata[134:71];
    chain[0].ends     = s_axis_tdata[135];
    chain[0].price    = s_axis_tdata[199:136];
    chain[0].volume   = s_axis_tdata[263:200];
    chain[0].any      = 1'b0;
    chain[0].group    = 1'b1;
  end

  assign s_axis_tready = en;

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    pcsf_cell #(
      .IDX(g),
      .NW (NW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .active_n_i (active_n),
      .item_i     (chain[g]),
      .item_o     (chain[g+1])
    );
  end

  pcsf_result_unit u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (chain[MAX_TERMS]),
    .en_o        (en),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.cnt, res.idx};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

FILE: src/pcsf_checker.sv
// ----------------------------------------------------------------------------
// pcsf_checker
// Port-level checks on the result stream of the scan filter.
// ----------------------------------------------------------------------------
module pcsf_checker
  import pcsf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // The match count always closes the results of its row.
  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_COUNT) |-> m_axis_tlast)
    else $error("count result without last");

  a_count_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_COUNT) |-> (m_axis_tdata[31:0] == '0))
    else $error("count result carries a row index");

  a_index_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_INDEX) |-> (m_axis_tdata[63:32] == '0))
    else $error("index result carries a count");

endmodule

bind column_predicate_scan_filter_unit pcsf_checker u_pcsf_checker (.*);
